### rtl/core/kth_permutation_unrank_unit_macros.svh
// Assertion macros for the permutation unrank unit.
// Used by modules that check their own internal behavior; needs clk and rst in scope.
`ifndef KTH_PERMUTATION_UNRANK_UNIT_MACROS_SVH
`define KTH_PERMUTATION_UNRANK_UNIT_MACROS_SVH

// Checked property, switched off while reset is high.
`define KPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define KPU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/kpu_pkg.sv
// Shared constants for the permutation unrank unit.
// No dependencies; used by every module of the block.
`default_nettype none
package kpu_pkg;

  // Fixed field widths.
  localparam int RANK_W  = 45;
  localparam int COUNT_W = 5;
  localparam int FIELD_W = 4;
  localparam int FACT_W  = 64;

  localparam int MAX_ELEMENTS_DEFAULT = 16;
  localparam int COUNT_RESET          = 16;

  // Factorials 0! through 20!.
  localparam logic [FACT_W-1:0] FACT_TABLE [0:20] = '{
    64'd1, 64'd1, 64'd2, 64'd6, 64'd24, 64'd120, 64'd720, 64'd5040, 64'd40320,
    64'd362880, 64'd3628800, 64'd39916800, 64'd479001600, 64'd6227020800,
    64'd87178291200, 64'd1307674368000, 64'd20922789888000,
    64'd355687428096000, 64'd6402373705728000, 64'd121645100408832000,
    64'd2432902008176640000
  };

endpackage
`default_nettype wire

### rtl/core/kpu_front.sv
// Input register and range check stage of the permutation unrank unit.
// Depends on kpu_pkg for widths and the factorial table.
`default_nettype none
module kpu_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic                         in_valid,
  input  wire logic [kpu_pkg::RANK_W-1:0]   in_rank,
  input  wire logic [kpu_pkg::COUNT_W-1:0]  in_count,
  output logic                              out_valid,
  output logic                              out_err,
  output logic [kpu_pkg::RANK_W-1:0]        out_rem,
  output logic [kpu_pkg::COUNT_W-1:0]       out_count
);

  logic                         a_valid;
  logic [kpu_pkg::RANK_W-1:0]   a_rank;
  logic [kpu_pkg::COUNT_W-1:0]  a_count;
  logic                         err_next;
  logic [kpu_pkg::FACT_W-1:0]   rank_wide;

  // A rank of zero or above n! is out of range.
  always_comb begin
    rank_wide = {{(kpu_pkg::FACT_W-kpu_pkg::RANK_W){1'b0}}, a_rank};
    err_next  = (a_rank == '0) || (rank_wide > kpu_pkg::FACT_TABLE[a_count]);
  end

  // Two register stages: capture, then check and form the zero-based rank.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
    if (advance) begin
      a_rank    <= in_rank;
      a_count   <= in_count;
      out_err   <= err_next;
      out_rem   <= err_next ? '0 : a_rank - kpu_pkg::RANK_W'(1);
      out_count <= a_count;
    end
  end

endmodule
`default_nettype wire

### rtl/core/kpu_digit_stage.sv
// One factorial digit stage: divides the remainder by (LEN-1)! for a fixed LEN.
// Depends on kpu_pkg for widths and the factorial table.
`default_nettype none
module kpu_digit_stage #(
  parameter int MAX_ELEMENTS = kpu_pkg::MAX_ELEMENTS_DEFAULT,
  parameter int LEN          = 1,
  parameter int DIGIT_W      = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic                              in_valid,
  input  wire logic                              in_err,
  input  wire logic [kpu_pkg::RANK_W-1:0]        in_rem,
  input  wire logic [kpu_pkg::COUNT_W-1:0]       in_count,
  input  wire logic [MAX_ELEMENTS*DIGIT_W-1:0]   in_digits,
  output logic                                   out_valid,
  output logic                                   out_err,
  output logic [kpu_pkg::RANK_W-1:0]             out_rem,
  output logic [kpu_pkg::COUNT_W-1:0]            out_count,
  output logic [MAX_ELEMENTS*DIGIT_W-1:0]        out_digits
);

  localparam logic [kpu_pkg::FACT_W-1:0] STEP = kpu_pkg::FACT_TABLE[LEN-1];

  logic [kpu_pkg::FACT_W-1:0]         rem_wide;
  logic [kpu_pkg::FACT_W-1:0]         sub;
  logic [DIGIT_W-1:0]                 digit;
  logic [MAX_ELEMENTS*DIGIT_W-1:0]    digits_next;

  // The remainder is below LEN!, so the digit is the number of multiples
  // of (LEN-1)! that it reaches; all compares run side by side.
  always_comb begin
    rem_wide = {{(kpu_pkg::FACT_W-kpu_pkg::RANK_W){1'b0}}, in_rem};
    digit    = '0;
    for (int m = 1; m < LEN; m++) begin
      if (rem_wide >= kpu_pkg::FACT_W'(m) * STEP) begin
        digit = digit + DIGIT_W'(1);
      end
    end
    sub = '0;
    for (int m = 1; m < LEN; m++) begin
      if (digit == DIGIT_W'(m)) begin
        sub = kpu_pkg::FACT_W'(m) * STEP;
      end
    end
    digits_next = in_digits;
    digits_next[(LEN-1)*DIGIT_W +: DIGIT_W] = digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_err    <= in_err;
      out_rem    <= in_rem - sub[kpu_pkg::RANK_W-1:0];
      out_count  <= in_count;
      out_digits <= digits_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/kpu_emitter.sv
// Result sequencer: turns the factorial digits of one rank into positions and elements.
// Depends on kpu_pkg and the assertion macro header.
`default_nettype none
`include "kth_permutation_unrank_unit_macros.svh"
module kpu_emitter #(
  parameter int MAX_ELEMENTS = kpu_pkg::MAX_ELEMENTS_DEFAULT,
  parameter int DIGIT_W      = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire logic                              in_err,
  input  wire logic [kpu_pkg::COUNT_W-1:0]       in_count,
  input  wire logic [MAX_ELEMENTS*DIGIT_W-1:0]   in_digits,
  output logic                                   ready,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kpu_pkg::FIELD_W-1:0]            out_position,
  output logic [kpu_pkg::FIELD_W-1:0]            out_element,
  output logic                                   out_last,
  output logic                                   out_error
);

  logic                              busy;
  logic                              err;
  logic [kpu_pkg::COUNT_W-1:0]       count;
  logic [DIGIT_W-1:0]                pos;
  logic [MAX_ELEMENTS*DIGIT_W-1:0]   digits;
  logic [DIGIT_W-1:0]                pool [MAX_ELEMENTS];
  logic [DIGIT_W-1:0]                pool_next [MAX_ELEMENTS];
  logic [kpu_pkg::COUNT_W-1:0]       slot_wide;
  logic [DIGIT_W-1:0]                digit;
  logic                              last_now;
  logic                              fire;

  // The digit for position p sits at slot n-1-p; it indexes the sorted pool.
  always_comb begin
    slot_wide = count - kpu_pkg::COUNT_W'(1) - kpu_pkg::COUNT_W'(pos);
    digit     = digits[slot_wide[DIGIT_W-1:0]*DIGIT_W +: DIGIT_W];
    last_now  = err || (kpu_pkg::COUNT_W'(pos) == count - kpu_pkg::COUNT_W'(1));
    fire      = busy && !out_stall;
    ready     = !busy || (fire && last_now);
    for (int j = 0; j < MAX_ELEMENTS; j++) begin
      if (j < MAX_ELEMENTS - 1 && DIGIT_W'(j) >= digit) begin
        pool_next[j] = pool[j+1];
      end else begin
        pool_next[j] = pool[j];
      end
    end
  end

  // Outputs come straight from the held state, so they hold while stalled.
  assign out_valid    = busy;
  assign out_last     = last_now;
  assign out_error    = err;
  assign out_position = err ? '0 : kpu_pkg::FIELD_W'(pos);
  assign out_element  = err ? '0 : kpu_pkg::FIELD_W'(pool[digit]);

  // Sequencer state: load a new rank, or step past one transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (fire && last_now) begin
      busy <= 1'b0;
    end
    if (load) begin
      err    <= in_err;
      count  <= in_count;
      digits <= in_digits;
      pos    <= '0;
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
        pool[j] <= DIGIT_W'(j);
      end
    end else if (fire && !last_now) begin
      pos  <= pos + DIGIT_W'(1);
      pool <= pool_next;
    end
  end

  `KPU_ASSERT(error_is_last, busy && err |-> last_now, "error result must be the last one")
  `KPU_ASSERT(pos_steps, fire && !last_now |=> busy && pos == $past(pos) + DIGIT_W'(1),
    "position must advance by one after a transaction")
  `KPU_ASSERT(pos_in_range, busy && !err |-> kpu_pkg::COUNT_W'(pos) < count,
    "position beyond element count")
  `KPU_ASSERT_ALWAYS(idle_after_reset, $past(rst) |-> !busy, "sequencer busy after reset")

endmodule
`default_nettype wire

### rtl/core/kth_permutation_unrank_unit.sv
// Permutation unrank unit: the first result follows the rank transaction through the
// input register, range check, one digit stage per element and the sequencer.
// A rank gives n results, one per cycle while result_stall is low; the sequencer takes
// the next rank as the last result is taken, and an out-of-range rank gives one result.
// Synchronous reset clears all valid bits and sets the element count to 16, or to MAX_ELEMENTS if smaller.
`default_nettype none
module kth_permutation_unrank_unit #(
  parameter int MAX_ELEMENTS = kpu_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_enable,
  input  wire logic [kpu_pkg::COUNT_W-1:0]   write_data,
  input  wire logic                          rank_valid,
  output logic                               rank_stall,
  input  wire logic [kpu_pkg::RANK_W-1:0]    rank,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [kpu_pkg::FIELD_W-1:0]        position,
  output logic [kpu_pkg::FIELD_W-1:0]        element,
  output logic                               last,
  output logic                               error
);

  localparam int DIGIT_W = $clog2(MAX_ELEMENTS);
  localparam int COUNT_INIT = (kpu_pkg::COUNT_RESET > MAX_ELEMENTS) ?
                              MAX_ELEMENTS : kpu_pkg::COUNT_RESET;

  logic [kpu_pkg::COUNT_W-1:0]      elements_in_use;
  logic                             advance;
  logic                             emit_ready;
  logic                             st_valid  [MAX_ELEMENTS+1];
  logic                             st_err    [MAX_ELEMENTS+1];
  logic [kpu_pkg::RANK_W-1:0]       st_rem    [MAX_ELEMENTS+1];
  logic [kpu_pkg::COUNT_W-1:0]      st_count  [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS*DIGIT_W-1:0]  st_digits [MAX_ELEMENTS+1];

  // Element count register, clamped into 1..MAX_ELEMENTS when written.
  always_ff @(posedge clk) begin
    if (rst) begin
      elements_in_use <= kpu_pkg::COUNT_W'(COUNT_INIT);
    end else if (write_enable) begin
      if (write_data == '0) begin
        elements_in_use <= kpu_pkg::COUNT_W'(1);
      end else if (write_data > kpu_pkg::COUNT_W'(MAX_ELEMENTS)) begin
        elements_in_use <= kpu_pkg::COUNT_W'(MAX_ELEMENTS);
      end else begin
        elements_in_use <= write_data;
      end
    end
  end

  // The whole pipeline moves unless its last stage holds an item the sequencer cannot take.
  assign advance    = !(st_valid[MAX_ELEMENTS] && !emit_ready);
  assign rank_stall = !advance;

  kpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (rank_valid),
    .in_rank   (rank),
    .in_count  (elements_in_use),
    .out_valid (st_valid[0]),
    .out_err   (st_err[0]),
    .out_rem   (st_rem[0]),
    .out_count (st_count[0])
  );
  assign st_digits[0] = '0;

  // One digit stage per length, from MAX_ELEMENTS down to one.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_digit
    kpu_digit_stage #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEN          (MAX_ELEMENTS - i),
      .DIGIT_W      (DIGIT_W)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .in_valid   (st_valid[i]),
      .in_err     (st_err[i]),
      .in_rem     (st_rem[i]),
      .in_count   (st_count[i]),
      .in_digits  (st_digits[i]),
      .out_valid  (st_valid[i+1]),
      .out_err    (st_err[i+1]),
      .out_rem    (st_rem[i+1]),
      .out_count  (st_count[i+1]),
      .out_digits (st_digits[i+1])
    );
  end

  kpu_emitter #(.MAX_ELEMENTS(MAX_ELEMENTS), .DIGIT_W(DIGIT_W)) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .load         (st_valid[MAX_ELEMENTS] && emit_ready),
    .in_err       (st_err[MAX_ELEMENTS]),
    .in_count     (st_count[MAX_ELEMENTS]),
    .in_digits    (st_digits[MAX_ELEMENTS]),
    .ready        (emit_ready),
    .out_valid    (result_valid),
    .out_stall    (result_stall),
    .out_position (position),
    .out_element  (element),
    .out_last     (last),
    .out_error    (error)
  );

endmodule
`default_nettype wire
